// ===== hdl/cps_pkg.sv =====
// shared widths, beat types and cell control types for the capped priority store
package cps_pkg;

    localparam int KEY_W     = 32;
    localparam int PRI_W     = 16;
    localparam int PAY_W     = 32;
    localparam int CNT_W     = 5;
    localparam int DEPTH_DEF = 16;

    // operation codes
    localparam logic OP_PUT   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // status codes
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_INVALID = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [KEY_W-1:0] key;
        logic [PRI_W-1:0] priority_req;
        logic [PAY_W-1:0] payload;
        logic             has_content;
        logic [CNT_W-1:0] top_count;
    } req_t;

    typedef struct packed {
        logic             status;
        logic             entry_valid;
        logic [KEY_W-1:0] out_key;
        logic [PRI_W-1:0] out_priority;
        logic [PAY_W-1:0] out_payload;
        logic [CNT_W-1:0] entry_count;
        logic             last;
    } res_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PRI_W-1:0] pri;
        logic [PAY_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic load;
        logic shift;
    } ent_ctl_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic insert;
    } sort_ctl_t;

endpackage

// ===== hdl/cps_entry_cell.sv =====
// one table slot: loads a new entry or takes its right neighbor's entry
module cps_entry_cell (
    input  logic              clk,
    input  cps_pkg::ent_ctl_t ctl,
    input  cps_pkg::entry_t   wr_data,
    input  cps_pkg::entry_t   nbr,
    output cps_pkg::entry_t   q
);
    import cps_pkg::*;

    entry_t q_reg;

    // load has priority; shift closes a gap left by a removal
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            q_reg <= wr_data;
        end
        else if (ctl.shift)
        begin
            q_reg <= nbr;
        end
    end

    assign q = q_reg;

endmodule

// ===== hdl/cps_sort_cell.sv =====
// one slot of the rotating sort row: priority and table index
module cps_sort_cell #(
    parameter int IDX_W = 4
) (
    input  logic                     clk,
    input  cps_pkg::sort_ctl_t       ctl,
    input  logic [cps_pkg::PRI_W-1:0] ld_pri,
    input  logic [IDX_W-1:0]         ld_idx,
    input  logic [cps_pkg::PRI_W-1:0] nbr_pri,
    input  logic [IDX_W-1:0]         nbr_idx,
    input  logic [cps_pkg::PRI_W-1:0] ins_pri,
    input  logic [IDX_W-1:0]         ins_idx,
    output logic [cps_pkg::PRI_W-1:0] pri,
    output logic [IDX_W-1:0]         idx
);
    import cps_pkg::*;

    logic [PRI_W-1:0] pri_reg;
    logic [IDX_W-1:0] idx_reg;

    // load from the table, take the neighbor, or take the rotated-in value
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            pri_reg <= ld_pri;
            idx_reg <= ld_idx;
        end
        else if (ctl.insert)
        begin
            pri_reg <= ins_pri;
            idx_reg <= ins_idx;
        end
        else if (ctl.shift)
        begin
            pri_reg <= nbr_pri;
            idx_reg <= nbr_idx;
        end
    end

    assign pri = pri_reg;
    assign idx = idx_reg;

endmodule

// ===== hdl/capped_priority_store.sv =====
// top level of the capped priority store: control sequencer and the two cell rows
//
// Usage: an item (req) is taken at a clock edge with start high and busy low.
// A put gives one result beat; a query gives one beat per reported entry, or
// a single beat with entry_valid low when nothing is reported. Each result
// beat is on result for exactly one cycle with result_valid high; the
// receiver cannot stall it. The capacity register is written over
// cfg_valid/cfg_ready (always ready); the user must write it only while
// the block is idle (the block itself does not enforce this). A known-key or
// invalid put answers from S_PUT; a new key is stored in S_PUT and, per
// eviction, followed by a minimum scan over the entry cells (S_SCAN) and
// a shift that closes the gap (S_REMOVE). A query loads the sort row at
// acceptance, then per reported entry pops the head (S_QPOP), compares each
// entry left in the rotating sort row with the champion (S_QCMP) and emits
// the champion. An empty query answers in the cycle after acceptance. Reset
// empties the table and sets capacity to 0 (full depth); entry data stays.
module capped_priority_store #(
    parameter int DEPTH = cps_pkg::DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  cps_pkg::req_t              req,
    output logic                       result_valid,
    output cps_pkg::res_t              result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [cps_pkg::CNT_W-1:0]  cfg_data
);
    import cps_pkg::*;

    localparam int NCELL  = DEPTH + 1;
    localparam int IDX_W  = $clog2(NCELL);
    localparam int FILL_W = $clog2(DEPTH + 2);
    localparam int SIDX_W = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PUT    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_REMOVE = 3'd3;
    localparam logic [2:0] S_QPOP   = 3'd4;
    localparam logic [2:0] S_QCMP   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0]  cap_reg;
    req_t              req_reg, req_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  low_reg, low_next;
    logic [PRI_W-1:0]  min_reg, min_next;
    logic [FILL_W-1:0] rem_reg, rem_next;
    logic [FILL_W-1:0] cnt_reg, cnt_next;
    logic [FILL_W-1:0] want_reg, want_next;
    logic [FILL_W-1:0] oi_reg, oi_next;
    logic [PRI_W-1:0]  champ_pri_reg, champ_pri_next;
    logic [SIDX_W-1:0] champ_idx_reg, champ_idx_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;

    entry_t            ent_q   [NCELL];
    ent_ctl_t          ent_ctl [NCELL];
    logic [PRI_W-1:0]  srt_pri [DEPTH];
    logic [SIDX_W-1:0] srt_idx [DEPTH];
    sort_ctl_t         srt_ctl [DEPTH];
    logic [PRI_W-1:0]  ins_pri;
    logic [SIDX_W-1:0] ins_idx;
    entry_t            wr_data;

    logic [FILL_W-1:0] cap_eff;
    logic              hit_any;
    logic [IDX_W-1:0]  hit_idx;
    logic [FILL_W-1:0] want_calc;
    entry_t            rd_entry;

    assign wr_data = '{key: req_reg.key, pri: req_reg.priority_req, payload: req_reg.payload};

    // entry cell row
    for (genvar k = 0; k < NCELL; k++)
    begin : g_ent
        entry_t nbr;
        if (k < NCELL - 1)
        begin : g_mid
            assign nbr = ent_q[k+1];
        end
        else
        begin : g_end
            assign nbr = '0;
        end
        cps_entry_cell u_cell (
            .clk     (clk),
            .ctl     (ent_ctl[k]),
            .wr_data (wr_data),
            .nbr     (nbr),
            .q       (ent_q[k])
        );
    end

    // sort cell row
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_srt
        logic [PRI_W-1:0]  nbr_pri;
        logic [SIDX_W-1:0] nbr_idx;
        if (k < DEPTH - 1)
        begin : g_mid
            assign nbr_pri = srt_pri[k+1];
            assign nbr_idx = srt_idx[k+1];
        end
        else
        begin : g_end
            assign nbr_pri = '0;
            assign nbr_idx = '0;
        end
        cps_sort_cell #(.IDX_W(SIDX_W)) u_cell (
            .clk     (clk),
            .ctl     (srt_ctl[k]),
            .ld_pri  (ent_q[k].pri),
            .ld_idx  (SIDX_W'(k)),
            .nbr_pri (nbr_pri),
            .nbr_idx (nbr_idx),
            .ins_pri (ins_pri),
            .ins_idx (ins_idx),
            .pri     (srt_pri[k]),
            .idx     (srt_idx[k])
        );
    end

    // effective capacity
    always_comb
    begin
        if (cap_reg == '0 || 32'(cap_reg) > 32'(DEPTH))
        begin
            cap_eff = FILL_W'(DEPTH);
        end
        else
        begin
            cap_eff = FILL_W'(cap_reg);
        end
    end

    // key match over the stored cells, lowest position wins
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int k = NCELL - 1; k >= 0; k--)
        begin
            if ((32'(k) < 32'(fill_reg)) && ent_q[k].key == req_reg.key)
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(k);
            end
        end
    end

    // number of entries a query reports
    always_comb
    begin
        if (32'(req.top_count) > 32'(fill_reg))
        begin
            want_calc = fill_reg;
        end
        else
        begin
            want_calc = FILL_W'(req.top_count);
        end
    end

    assign rd_entry = ent_q[IDX_W'(champ_idx_reg)];

    // winner of a compare goes on as champion, loser rotates to the tail
    always_comb
    begin
        if (champ_pri_reg < srt_pri[0])
        begin
            ins_pri = champ_pri_reg;
            ins_idx = champ_idx_reg;
        end
        else
        begin
            ins_pri = srt_pri[0];
            ins_idx = srt_idx[0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        req_next       = req_reg;
        j_next         = j_reg;
        low_next       = low_reg;
        min_next       = min_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        want_next      = want_reg;
        oi_next        = oi_reg;
        champ_pri_next = champ_pri_reg;
        champ_idx_next = champ_idx_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        for (int k = 0; k < NCELL; k++)
        begin
            ent_ctl[k] = '0;
        end
        for (int k = 0; k < DEPTH; k++)
        begin
            srt_ctl[k] = '0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    if (req.operation == OP_PUT)
                    begin
                        state_next = S_PUT;
                    end
                    else if (want_calc == '0)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '0;
                        res_next.status      = ST_OK;
                        res_next.entry_count = CNT_W'(fill_reg);
                        res_next.last        = 1'b1;
                    end
                    else
                    begin
                        for (int k = 0; k < DEPTH; k++)
                        begin
                            srt_ctl[k].load = 1'b1;
                        end
                        want_next  = want_calc;
                        rem_next   = fill_reg;
                        oi_next    = '0;
                        state_next = S_QPOP;
                    end
                end
            end

            S_PUT:
            begin
                res_next = '0;
                res_next.last = 1'b1;
                if (req_reg.key == '0 || !req_reg.has_content)
                begin
                    res_valid_next       = 1'b1;
                    res_next.status      = ST_INVALID;
                    res_next.entry_count = CNT_W'(fill_reg);
                    state_next           = S_IDLE;
                end
                else if (hit_any)
                begin
                    ent_ctl[hit_idx].load = 1'b1;
                    res_valid_next        = 1'b1;
                    res_next.entry_count  = CNT_W'(fill_reg);
                    state_next            = S_IDLE;
                end
                else
                begin
                    ent_ctl[IDX_W'(fill_reg)].load = 1'b1;
                    fill_next = fill_reg + 1'b1;
                    if (fill_reg + 1'b1 > cap_eff)
                    begin
                        j_next     = '0;
                        low_next   = '0;
                        min_next   = '1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        res_valid_next       = 1'b1;
                        res_next.entry_count = CNT_W'(fill_reg + 1'b1);
                        state_next           = S_IDLE;
                    end
                end
            end

            S_SCAN:
            begin
                if (ent_q[j_reg].pri < min_reg)
                begin
                    min_next = ent_q[j_reg].pri;
                    low_next = j_reg;
                end
                if (FILL_W'(j_reg) == fill_reg - 1'b1)
                begin
                    state_next = S_REMOVE;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end

            S_REMOVE:
            begin
                for (int k = 0; k < NCELL; k++)
                begin
                    if (IDX_W'(k) >= low_reg)
                    begin
                        ent_ctl[k].shift = 1'b1;
                    end
                end
                fill_next = fill_reg - 1'b1;
                if (fill_reg - 1'b1 > cap_eff)
                begin
                    j_next     = '0;
                    low_next   = '0;
                    min_next   = '1;
                    state_next = S_SCAN;
                end
                else
                begin
                    res_valid_next       = 1'b1;
                    res_next             = '0;
                    res_next.entry_count = CNT_W'(fill_reg - 1'b1);
                    res_next.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            S_QPOP:
            begin
                champ_pri_next = srt_pri[0];
                champ_idx_next = srt_idx[0];
                for (int k = 0; k < DEPTH; k++)
                begin
                    srt_ctl[k].shift = 1'b1;
                end
                rem_next   = rem_reg - 1'b1;
                cnt_next   = rem_reg - 1'b1;
                state_next = S_QCMP;
            end

            S_QCMP:
            begin
                if (cnt_reg == '0)
                begin
                    res_valid_next        = 1'b1;
                    res_next.status       = ST_OK;
                    res_next.entry_valid  = 1'b1;
                    res_next.out_key      = rd_entry.key;
                    res_next.out_priority = rd_entry.pri;
                    res_next.out_payload  = rd_entry.payload;
                    res_next.entry_count  = CNT_W'(fill_reg);
                    res_next.last         = (oi_reg + 1'b1 == want_reg);
                    oi_next               = oi_reg + 1'b1;
                    if (oi_reg + 1'b1 == want_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_QPOP;
                    end
                end
                else
                begin
                    // rotate the remaining entries by one through the champion
                    for (int k = 0; k < DEPTH; k++)
                    begin
                        if (32'(k) + 1 < 32'(rem_reg))
                        begin
                            srt_ctl[k].shift = 1'b1;
                        end
                        else if (32'(k) + 1 == 32'(rem_reg))
                        begin
                            srt_ctl[k].insert = 1'b1;
                        end
                    end
                    if (champ_pri_reg < srt_pri[0])
                    begin
                        champ_pri_next = srt_pri[0];
                        champ_idx_next = srt_idx[0];
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            cap_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        j_reg         <= j_next;
        low_reg       <= low_next;
        min_reg       <= min_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        want_reg      <= want_next;
        oi_reg        <= oi_next;
        champ_pri_reg <= champ_pri_next;
        champ_idx_reg <= champ_idx_next;
        res_reg       <= res_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
